FILE: design/sms_pkg.sv
// types, codes and value helpers shared by the sparse matrix store
`default_nettype none
package sms_pkg;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  row_index;
    logic [7:0]  col_index;
    logic [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        status;
  } out_t;

  function automatic logic word_is_zero(input logic [31:0] w);
    return w[30:0] == 31'd0;
  endfunction

  function automatic logic word_is_nan(input logic [31:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
  endfunction

  // ieee equality: nan never equal, both zeros equal
  function automatic logic words_equal(input logic [31:0] a, input logic [31:0] b);
    logic res;
    if (word_is_nan(a) || word_is_nan(b)) begin
      res = 1'b0;
    end else if (word_is_zero(a) && word_is_zero(b)) begin
      res = 1'b1;
    end else begin
      res = (a == b);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/sms_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module sms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/sparse_matrix_row_list_store_top.sv
// sparse matrix store: per-row linked lists of nonzero entries in ram
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, in_data      | request in
//  out     | out_valid, out_stall, out_data   | result out
//
// a request steps through the head read, the walk over the list nodes up
// to and including the matching node, and the decide step; a tail append
// adds a link patch step. the walk follows the entry ram's registered
// read, one node per cycle. after reset the row head ram is cleared, one
// row per cycle, and no request is taken during that pass.
// the result register holds while out_stall is high; a new request is taken
// once the result register is free or being drained.
`default_nettype none
module sparse_matrix_row_list_store_top
  import sms_pkg::*;
#(
  parameter int ROWS    = 256,
  parameter int COLS    = 256,
  parameter int ENTRIES = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);
  localparam int RW = ROWS > 1 ? $clog2(ROWS) : 1;     // row address width
  localparam int SW = ENTRIES > 1 ? $clog2(ENTRIES) : 1; // slot address width
  localparam int LW = $clog2(ENTRIES + 1);             // link: slot + 1, 0 = end

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_HEAD   = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_LINK   = 3'd5;

  localparam logic [LW-1:0] LINK_END = '0;
  localparam logic [LW-1:0] LINK_ONE = LW'(1);
  localparam logic [LW-1:0] ENT_ALL  = LW'(ENTRIES);

  logic [2:0]    state_r, state_nxt;
  in_t           req_r, req_nxt;
  logic          oor_r, oor_nxt;        // row or column out of range
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   old_r, old_nxt;
  logic [LW-1:0] link_r, link_nxt;      // successor of the matched slot
  logic [SW-1:0] ns_r, ns_nxt;          // slot just appended
  logic [RW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] fresh_r, fresh_nxt;    // slots never handed out start here
  logic [LW-1:0] scnt_r, scnt_nxt;      // recycled slots on the stack
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  // ram ports
  logic          head_we;
  logic [RW-1:0] head_waddr, head_raddr;
  logic [LW-1:0] head_wdata, head_rdata;
  logic          cw_we;
  logic [SW-1:0] cw_waddr, ent_raddr;
  logic [39:0]   cw_wdata, cw_rdata;
  logic          lk_we;
  logic [SW-1:0] lk_waddr;
  logic [LW-1:0] lk_wdata, lk_rdata;
  logic          stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  logic          accept;
  logic          do_wr, insert, remove, has_free;
  logic [SW-1:0] slot, new_slot;
  logic [31:0]   old_val;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // read addresses: head at transfer time, entries follow the walk
  assign head_raddr = RW'(in_data.row_index);
  assign ent_raddr  = (state_r == ST_HEAD) ? SW'(head_rdata - LINK_ONE)
                                           : SW'(lk_rdata - LINK_ONE);
  assign stk_raddr  = SW'(scnt_r - LINK_ONE);

  assign old_val  = found_r ? old_r : 32'd0;
  assign slot     = SW'(cur_r - LINK_ONE);
  assign has_free = (fresh_r != ENT_ALL) || (scnt_r != LINK_END);
  assign new_slot = (scnt_r != LINK_END) ? stk_rdata : SW'(fresh_r);
  assign do_wr    = (req_r.req_type == REQ_WRITE) && !oor_r &&
                    !words_equal(old_val, req_r.write_value);
  assign insert   = do_wr && !found_r;
  assign remove   = do_wr && found_r && word_is_zero(req_r.write_value);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    oor_nxt       = oor_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    found_nxt     = found_r;
    old_nxt       = old_r;
    link_nxt      = link_r;
    ns_nxt        = ns_r;
    clr_nxt       = clr_r;
    fresh_nxt     = fresh_r;
    scnt_nxt      = scnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    head_we    = 1'b0;
    head_waddr = RW'(req_r.row_index);
    head_wdata = LINK_END;
    cw_we      = 1'b0;
    cw_waddr   = slot;
    cw_wdata   = {req_r.col_index, req_r.write_value};
    lk_we      = 1'b0;
    lk_waddr   = SW'(prev_r - LINK_ONE);
    lk_wdata   = link_r;
    stk_we     = 1'b0;
    stk_waddr  = SW'(scnt_r);
    stk_wdata  = slot;

    unique case (state_r)
      ST_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        clr_nxt    = clr_r + RW'(1);
        if (32'(clr_r) == ROWS - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_data;
          oor_nxt   = (32'(in_data.row_index) >= ROWS) || (32'(in_data.col_index) >= COLS);
          prev_nxt  = LINK_END;
          found_nxt = 1'b0;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cur_nxt = head_rdata;
        if (oor_r || head_rdata == LINK_END) begin
          state_nxt = ST_DECIDE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cw_rdata[39:32] == req_r.col_index) begin
          found_nxt = 1'b1;
          old_nxt   = cw_rdata[31:0];
          link_nxt  = lk_rdata;
          state_nxt = ST_DECIDE;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = lk_rdata;
          if (lk_rdata == LINK_END) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        out_valid_nxt     = 1'b1;
        out_nxt.read_value = old_val;
        out_nxt.status    = STATUS_DONE;
        state_nxt         = ST_IDLE;
        if (insert) begin
          if (!has_free) begin
            out_nxt.status = STATUS_FULL;
          end else begin
            if (scnt_r != LINK_END) begin
              scnt_nxt = scnt_r - LINK_ONE;
            end else begin
              fresh_nxt = fresh_r + LINK_ONE;
            end
            cw_we    = 1'b1;
            cw_waddr = new_slot;
            lk_we    = 1'b1;
            lk_waddr = new_slot;
            lk_wdata = LINK_END;
            if (prev_r == LINK_END) begin
              head_we    = 1'b1;
              head_wdata = LW'(new_slot) + LINK_ONE;
            end else begin
              ns_nxt    = new_slot;
              state_nxt = ST_LINK;
            end
          end
        end else if (remove) begin
          // unlink the entry and push its slot
          if (prev_r == LINK_END) begin
            head_we    = 1'b1;
            head_wdata = link_r;
          end else begin
            lk_we = 1'b1;
          end
          stk_we   = 1'b1;
          scnt_nxt = scnt_r + LINK_ONE;
        end else if (do_wr) begin
          cw_we = 1'b1;
        end
      end
      ST_LINK: begin
        // patch the old tail to point at the new entry
        lk_we    = 1'b1;
        lk_wdata = LW'(ns_r) + LINK_ONE;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      fresh_r     <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fresh_r     <= fresh_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r   <= req_nxt;
    oor_r   <= oor_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    found_r <= found_nxt;
    old_r   <= old_nxt;
    link_r  <= link_nxt;
    ns_r    <= ns_nxt;
    out_r   <= out_nxt;
  end

  // row heads
  sms_ram #(.WIDTH(LW), .DEPTH(ROWS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  // entry column and value word
  sms_ram #(.WIDTH(40), .DEPTH(ENTRIES)) u_cw_ram (
    .clk(clk), .we(cw_we), .waddr(cw_waddr), .wdata(cw_wdata),
    .raddr(ent_raddr), .rdata(cw_rdata)
  );

  // entry links
  sms_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(ent_raddr), .rdata(lk_rdata)
  );

  // stack of recycled slots
  sms_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_free_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

endmodule
`default_nettype wire

FILE: test/sparse_matrix_row_list_store_top_tb.sv
// testbench for the sparse matrix row list store: random requests checked against a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module sparse_matrix_row_list_store_top_tb
  import sms_pkg::*;
;

  localparam int ROWS    = 256;
  localparam int COLS    = 256;
  localparam int ENTRIES = 1024;
  localparam int NUM_RANDOM = 200;
  localparam int NUM_DRAIN  = 200;

  // scoreboard: holds its own copy of the matrix, keyed by row and column
  class matrix_scoreboard;
    // cells kept per row and column key; list position in the store does not affect results
    logic [31:0] cell_word [int];
    bit          cell_used [int];
    int          used_count;
    out_t        pending_results [$];
    int          mismatch_count;

    function new();
      used_count = 0;
      mismatch_count = 0;
    endfunction

    // zero-pattern test, both signs
    function bit is_zero_word(logic [31:0] w);
      return w[30:0] == 31'd0;
    endfunction

    function bit is_nan_word(logic [31:0] w);
      return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
    endfunction

    function bit ieee_same(logic [31:0] a, logic [31:0] b);
      if (is_nan_word(a) || is_nan_word(b)) return 0;
      if (is_zero_word(a) && is_zero_word(b)) return 1;
      return a == b;
    endfunction

    // apply one accepted request and queue its result
    function void note_request(in_t req);
      int key;
      bit present;
      out_t res;
      key = req.row_index * 256 + req.col_index;
      present = cell_used.exists(key);
      res.read_value = present ? cell_word[key] : 32'd0;
      res.status = STATUS_DONE;
      if (req.req_type == REQ_WRITE && !ieee_same(res.read_value, req.write_value)) begin
        if (!present) begin
          if (used_count == ENTRIES) begin
            res.status = STATUS_FULL;
          end else begin
            cell_used[key] = 1;
            cell_word[key] = req.write_value;
            used_count++;
          end
        end else if (is_zero_word(req.write_value)) begin
          cell_used.delete(key);
          cell_word.delete(key);
          used_count--;
        end else begin
          cell_word[key] = req.write_value;
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: value %h status %b", got.read_value, got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value || got.status !== want.status) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result mismatch: expected %h/%b actual %h/%b",
                   want.read_value, want.status, got.read_value, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  matrix_scoreboard board;
  bit   stimulus_done;
  bit   long_holdoff_active;
  int   sent_count;

  sparse_matrix_row_list_store_top #(
    .ROWS(ROWS), .COLS(COLS), .ENTRIES(ENTRIES)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one request, hold it until the transfer happens, then maybe idle
  task automatic send_request(in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req);
    sent_count++;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_t make_request(bit wr, int row, int col, logic [31:0] val);
    in_t r;
    r.req_type = wr ? REQ_WRITE : REQ_READ;
    r.row_index = row[7:0];
    r.col_index = col[7:0];
    r.write_value = val;
    return r;
  endfunction

  // value mix: plenty of zeros, nans and repeats to hit every write path
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FC0_0000 | $urandom_range(0, 255);
      3: return 32'h3F80_0000;
      default: return $urandom();
    endcase
  endfunction

  // fill the store past capacity across 64 rows, checking refusal, then remove some entries
  task automatic fill_and_drain();
    int k;
    for (k = 0; k < ENTRIES + 6; k++)
      send_request(make_request(1, k % 64, k / 64 + 100, 32'h4000_0000 + k));
    send_request(make_request(0, 5, 110, 32'd0));
    for (k = 0; k < NUM_DRAIN; k++)
      send_request(make_request(1, k % 64, k / 64 + 100, k[0] ? 32'h8000_0000 : 32'd0));
  endtask

  initial begin
    in_t req;
    int  i;
    int  row;
    int  col;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stimulus_done = 0;
    sent_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, both zeros, nan cases, overwrite and removal
    send_request(make_request(0, 0, 0, 32'hFFFF_FFFF));
    send_request(make_request(1, 255, 255, 32'hFFFF_FFFF));
    send_request(make_request(0, 255, 255, 32'd0));
    send_request(make_request(1, 0, 0, 32'h8000_0000));
    send_request(make_request(1, 0, 0, 32'd0));
    send_request(make_request(1, 0, 0, 32'h7FC0_0001));
    send_request(make_request(1, 0, 0, 32'h7FC0_0001));
    send_request(make_request(1, 0, 1, 32'h3F80_0000));
    send_request(make_request(1, 0, 2, 32'h4000_0000));
    send_request(make_request(1, 0, 1, 32'h3F80_0000));
    send_request(make_request(1, 0, 1, 32'hBF80_0000));
    send_request(make_request(1, 0, 1, 32'h8000_0000));
    send_request(make_request(0, 0, 2, 32'd0));
    send_request(make_request(1, 0, 0, 32'd0));
    send_request(make_request(0, 0, 0, 32'd0));
    send_request(make_request(1, 255, 255, 32'd0));
    send_request(make_request(1, 128, 127, 32'h7F80_0000));
    send_request(make_request(0, 128, 127, 32'hAAAA_5555));

    // random: mostly a few hot rows so lists grow and shrink
    for (i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        row = $urandom_range(0, 255);
        col = $urandom_range(0, 255);
      end else begin
        row = $urandom_range(0, 7);
        col = $urandom_range(0, 31);
      end
      req = make_request($urandom_range(0, 2) != 0, row, col, pick_value());
      send_request(req);
    end

    // store full and refusal, then partly empty it again
    fill_and_drain();
    in_valid <= 1'b0;
    stimulus_done = 1;
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  initial begin
    int stall_len;
    out_stall = 1'b1;
    long_holdoff_active = 0;
    @(posedge rst_n);
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) board.check_result(out_data);
      if (sent_count >= 40 && !long_holdoff_active) begin
        long_holdoff_active = 1;
        out_stall <= 1'b1;
        repeat (400) begin
          @(posedge clk);
        end
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall && $urandom_range(0, 2) == 0) begin
        stall_len = $urandom_range(0, 13);
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // end of run: wait for the last expected transfer, then a short drain
  initial begin
    wait (stimulus_done);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 50) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending_results.size() == 0) begin
      $display("[sparse_matrix_row_list_store_top] OK");
    end else begin
      $display("[sparse_matrix_row_list_store_top] ERROR");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #(300_000_000);
    $display("[sparse_matrix_row_list_store_top] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
